>>> hdl/utrd_pkg.sv
package utrd_pkg;

  localparam int VALUE_W    = 64;
  localparam int SYM_W      = 8;
  localparam int DIGIT_W    = 4;
  localparam int BASE_W     = 5;
  localparam int MAX_DIGITS = 64;
  localparam int MAX_BASE   = 16;
  localparam int ADDR_W     = $clog2(MAX_DIGITS);
  localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
  localparam int STEP_BITS  = 8;
  localparam int STEPS      = VALUE_W / STEP_BITS;
  localparam int STEP_W     = $clog2(STEPS);
  localparam int CFG_IDX_W  = 2;

  localparam logic [SYM_W-1:0]   ZERO_SYMBOL      = 8'h30;
  localparam logic [BASE_W-1:0]  RESET_BASE       = 5'd10;
  localparam logic [VALUE_W-1:0] RESET_ALPHA_LOW  = 64'd3978425819141910832;
  localparam logic [VALUE_W-1:0] RESET_ALPHA_HIGH = 64'd111542271471928;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_HIGH = 2'd2;

  typedef struct packed {
    logic               zero;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [BASE_W-1:0]  base_size;
    logic [VALUE_W-1:0] alphabet_low;
    logic [VALUE_W-1:0] alphabet_high;
  } cfg_t;

  function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    r = b;
    if (b < BASE_W'(2)) r = BASE_W'(2);
    else if (b > BASE_W'(MAX_BASE)) r = BASE_W'(MAX_BASE);
    return r;
  endfunction

  function automatic logic [SYM_W-1:0] symbol_of(input cfg_t c, input logic [DIGIT_W-1:0] d);
    logic [2*VALUE_W-1:0] alpha;
    alpha = {c.alphabet_high, c.alphabet_low};
    return alpha[d*SYM_W +: SYM_W];
  endfunction

endpackage

>>> hdl/unsigned_to_radix_digits.sv
// Converts unsigned 64-bit values to digit symbols in base 2..16, MSB first.
// Input queue: drive value with push while full is low; one beat per value.
// Result queue: while empty is low, symbol/last hold the oldest beat; pop
// takes it. last marks the final symbol of a number; zero gives one '0'.
// Config channel: cfg_index 0 base_size, 1 alphabet_low, 2 alphabet_high;
// cfg_ready is always high, index 3 is ignored. Write only while idle.
// Division: the divider makes 8 quotient bits per cycle, and each digit
// takes a full pass over the 64-bit quotient; the digits are then read
// out of the store (at most 20 digits in base 10, 64 in base 2).
// A zero value skips the divider and gives its '0' directly.
// The front queue holds IN_DEPTH values so the input keeps taking beats
// while the back end divides. Readout waits until the result queue
// (OUT_DEPTH beats) has at least two free places, so a stalled receiver
// only delays results. Reset (rst, synchronous) empties both queues,
// aborts any conversion and restores base 10 with the reset alphabet.
module unsigned_to_radix_digits #(
  parameter int IN_DEPTH  = 2,
  parameter int OUT_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [63:0] value,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  symbol,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import utrd_pkg::*;

  localparam int LVL_W = $clog2(OUT_DEPTH + 1);

  cfg_t             cfg;
  item_t            item;
  logic             item_valid;
  logic             item_take;
  logic             res_room;
  logic             res_push;
  res_t             res_in;
  res_t             res_out;
  logic [LVL_W-1:0] res_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_size     <= RESET_BASE;
      cfg.alphabet_low  <= RESET_ALPHA_LOW;
      cfg.alphabet_high <= RESET_ALPHA_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE_SIZE:     cfg.base_size     <= cfg_data[BASE_W-1:0];
        CFG_ALPHABET_LOW:  cfg.alphabet_low  <= cfg_data;
        CFG_ALPHABET_HIGH: cfg.alphabet_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // one read may be in flight past the visible level
  assign res_room = (res_level <= LVL_W'(OUT_DEPTH - 2));

  utrd_front #(
    .DEPTH(IN_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .value      (value),
    .full       (full),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  utrd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .cfg        (cfg),
    .res_room   (res_room),
    .res_push   (res_push),
    .res        (res_in)
  );

  utrd_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(OUT_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (),
    .rd_en   (pop),
    .rd_data (res_out),
    .empty   (empty),
    .level   (res_level)
  );

  assign symbol = res_out.symbol;
  assign last   = res_out.last;

endmodule

>>> hdl/utrd_fifo.sv
module utrd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic [WIDTH-1:0]             wr_data,
  output logic                         full,
  input  logic                         rd_en,
  output logic [WIDTH-1:0]             rd_data,
  output logic                         empty,
  output logic [$clog2(DEPTH+1)-1:0]   level
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full    = (level == LVL_W'(DEPTH));
  assign empty   = (level == '0);
  assign rd_data = mem[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   level <= level + LVL_W'(1);
        2'b01:   level <= level - LVL_W'(1);
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

endmodule

>>> hdl/utrd_front.sv
module utrd_front #(
  parameter int DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic [63:0]             value,
  output logic                    full,
  output logic                    item_valid,
  output utrd_pkg::item_t         item,
  input  logic                    item_take
);
  import utrd_pkg::*;

  item_t in_item;
  logic  q_empty;

  // zero values take a short path in the back end, flag them here
  assign in_item.zero  = (value == '0);
  assign in_item.value = value;
  assign item_valid    = !q_empty;

  utrd_fifo #(
    .WIDTH($bits(item_t)),
    .DEPTH(DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (in_item),
    .full    (full),
    .rd_en   (item_take),
    .rd_data (item),
    .empty   (q_empty),
    .level   ()
  );

endmodule

>>> hdl/utrd_back.sv
module utrd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  utrd_pkg::item_t item,
  output logic            item_take,
  input  utrd_pkg::cfg_t  cfg,
  input  logic            res_room,
  output logic            res_push,
  output utrd_pkg::res_t  res
);
  import utrd_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_READ} state_t;

  state_t              state;
  logic [VALUE_W-1:0]  quot;
  logic [VALUE_W-1:0]  quot_next;
  logic [DIGIT_W-1:0]  rem;
  logic [DIGIT_W-1:0]  rem_next;
  logic [STEP_W-1:0]   step;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    k;
  logic [CNT_W-1:0]    rd_idx;
  logic                rd_pending;
  logic                rd_last;
  logic [DIGIT_W-1:0]  rd_digit;
  logic [DIGIT_W-1:0]  store [MAX_DIGITS];
  logic [BASE_W-1:0]   base;
  logic                zero_push;
  logic                rd_issue;
  logic                digit_done;

  assign base = eff_base(cfg.base_size);

  // restoring division, 8 quotient bits per cycle, MSB first
  always_comb begin
    logic [DIGIT_W-1:0]   r;
    logic [BASE_W-1:0]    t;
    logic [STEP_BITS-1:0] qb;
    r = rem;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      t = {r, quot[VALUE_W-STEP_BITS+i]};
      if (t >= base) begin
        qb[i] = 1'b1;
        t     = t - base;
      end else begin
        qb[i] = 1'b0;
      end
      r = t[DIGIT_W-1:0];
    end
    quot_next = {quot[VALUE_W-STEP_BITS-1:0], qb};
    rem_next  = r;
  end

  assign digit_done = (state == S_DIV) && (step == STEP_W'(STEPS - 1));
  assign item_take  = (state == S_IDLE) && item_valid && !rd_pending &&
                      (!item.zero || res_room);
  assign zero_push  = item_take && item.zero;
  assign rd_issue   = (state == S_READ) && res_room;
  assign rd_idx     = k - CNT_W'(1);

  assign res_push   = rd_pending || zero_push;
  assign res.symbol = rd_pending ? symbol_of(cfg, rd_digit) : ZERO_SYMBOL;
  assign res.last   = rd_pending ? rd_last : 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      cnt        <= '0;
      k          <= '0;
      rd_pending <= 1'b0;
      rd_last    <= 1'b0;
    end else begin
      rd_pending <= rd_issue;
      unique case (state)
        S_IDLE: begin
          if (item_take && !item.zero) begin
            quot  <= item.value;
            rem   <= '0;
            step  <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          quot <= quot_next;
          step <= step + STEP_W'(1);
          if (digit_done) begin
            rem <= '0;
            cnt <= cnt + CNT_W'(1);
            if (quot_next == '0 || cnt == CNT_W'(MAX_DIGITS - 1)) begin
              k     <= cnt + CNT_W'(1);
              state <= S_READ;
            end
          end else begin
            rem <= rem_next;
          end
        end
        S_READ: begin
          if (rd_issue) begin
            rd_last <= (k == CNT_W'(1));
            k       <= k - CNT_W'(1);
            if (k == CNT_W'(1)) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (digit_done) store[cnt[ADDR_W-1:0]] <= rem_next;
    if (rd_issue) rd_digit <= store[rd_idx[ADDR_W-1:0]];
  end

endmodule

>>> sim/radix_digit_checker.sv
module radix_digit_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic                           full,
  input  logic [utrd_pkg::VALUE_W-1:0]   value,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [utrd_pkg::SYM_W-1:0]     symbol,
  input  logic                           last,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [utrd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [utrd_pkg::VALUE_W-1:0]   cfg_data,
  output int                             errors,
  output int                             outstanding
);
  import utrd_pkg::*;

  logic [BASE_W-1:0]  radix_reg;
  logic [VALUE_W-1:0] glyphs_lo;
  logic [VALUE_W-1:0] glyphs_hi;
  res_t               symbols_due[$];

  function automatic logic [SYM_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    if (d[DIGIT_W-1]) begin
      return glyphs_hi[8*d[2:0] +: SYM_W];
    end
    return glyphs_lo[8*d[2:0] +: SYM_W];
  endfunction

  // Queues the symbol beats of one number, most significant digit first.
  task automatic queue_digits(input logic [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] q;
    logic [VALUE_W-1:0] radix;
    logic [DIGIT_W-1:0] digits [MAX_DIGITS];
    int                 n;
    res_t               beat;
    radix = VALUE_W'(radix_reg);
    if (radix < 2) radix = 2;
    if (radix > MAX_BASE) radix = MAX_BASE;
    if (v == '0) begin
      // fixed character, not the digit-0 alphabet entry
      beat.symbol = ZERO_SYMBOL;
      beat.last   = 1'b1;
      symbols_due.push_back(beat);
      return;
    end
    q = v;
    n = 0;
    while (q != '0) begin
      digits[n] = DIGIT_W'(q % radix);
      q = q / radix;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      beat.symbol = glyph(digits[k]);
      beat.last   = (k == 0);
      symbols_due.push_back(beat);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      radix_reg   = RESET_BASE;
      glyphs_lo   = RESET_ALPHA_LOW;
      glyphs_hi   = RESET_ALPHA_HIGH;
      symbols_due.delete();
      errors      = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BASE_SIZE:     radix_reg = cfg_data[BASE_W-1:0];
          CFG_ALPHABET_LOW:  glyphs_lo = cfg_data;
          CFG_ALPHABET_HIGH: glyphs_hi = cfg_data;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (symbols_due.size() == 0) begin
          $error("unexpected result beat: symbol %02h last %0b", symbol, last);
          errors++;
        end else begin
          want = symbols_due.pop_front();
          if (symbol !== want.symbol) begin
            $error("symbol mismatch: expected %02h, actual %02h", want.symbol, symbol);
            errors++;
          end
          if (last !== want.last) begin
            $error("last mismatch: expected %0b, actual %0b", want.last, last);
            errors++;
          end
        end
      end
      if (push && !full) queue_digits(value);
    end
    outstanding = symbols_due.size();
  end

endmodule

>>> sim/unsigned_to_radix_digits_tb.sv
module unsigned_to_radix_digits_tb;
  import utrd_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASES         = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam logic [VALUE_W-1:0]   ALL_ONES   = '1;

  logic                 clk;
  logic                 rst;
  logic                 push;
  logic                 full;
  logic [VALUE_W-1:0]   value;
  logic                 empty;
  logic                 pop;
  logic [SYM_W-1:0]     symbol;
  logic                 last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [VALUE_W-1:0]   cfg_data;

  int                errors;
  int                outstanding;
  int                quiet_cycles;
  int                gap_pct;
  bit                calm;
  logic [BASE_W-1:0] cur_base;

  unsigned_to_radix_digits i_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .value     (value),
    .empty     (empty),
    .pop       (pop),
    .symbol    (symbol),
    .last      (last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  radix_digit_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .value       (value),
    .empty       (empty),
    .pop         (pop),
    .symbol      (symbol),
    .last        (last),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Result side: pop runs and stall bursts; no stalls once calm.
  initial begin
    pop = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (calm || $urandom_range(0, 3) != 0) begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  // Leaves push high after the accepting edge; the caller either sends the
  // next beat or lowers push in that same step.
  task automatic send_value(input logic [VALUE_W-1:0] v);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    push  <= 1'b1;
    value <= v;
    do @(posedge clk); while (full);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain(input int extra);
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic load_settings(input logic [BASE_W-1:0] b, input logic [VALUE_W-1:0] lo,
                               input logic [VALUE_W-1:0] hi);
    drain(SETTLE_CYCLES);
    write_reg(CFG_BASE_SIZE, VALUE_W'(b));
    write_reg(CFG_ALPHABET_LOW, lo);
    write_reg(CFG_ALPHABET_HIGH, hi);
    cfg_valid <= 1'b0;
    cur_base = b;
  endtask

  initial begin
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] p;
    logic [VALUE_W-1:0] radix;
    logic [BASE_W-1:0]  b;
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] hi;
    int                 n;

    rst       = 1'b1;
    push      = 1'b0;
    value     = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_BASE_SIZE;
    cfg_data  = '0;
    calm      = 1'b0;
    gap_pct   = 25;
    cur_base  = RESET_BASE;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings first
    send_value('0);
    send_value(64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(64'd100);
    send_value(ALL_ONES);
    send_value(64'h8000_0000_0000_0000);

    load_settings(5'd2, {$urandom, $urandom}, {$urandom, $urandom});
    send_value(ALL_ONES);   // 64 digits
    send_value(64'd1);
    send_value('0);
    send_value(64'h8000_0000_0000_0000);

    load_settings(5'd16, '0, ALL_ONES);
    send_value(ALL_ONES);
    send_value(64'h0123_4567_89ab_cdef);
    send_value('0);

    // base 0 and 1 behave as base 2
    load_settings(5'd0, ALL_ONES, '0);
    send_value(64'd5);
    send_value(64'hffff);
    load_settings(5'd1, {$urandom, $urandom}, {$urandom, $urandom});
    send_value(64'd6);

    // bases above 16 behave as 16
    load_settings(5'd31, {$urandom, $urandom}, {$urandom, $urandom});
    send_value(ALL_ONES);
    send_value(64'hfedc_ba98_7654_3210);
    load_settings(5'd17, {$urandom, $urandom}, {$urandom, $urandom});
    send_value(64'd255);

    drain(SETTLE_CYCLES);
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    send_value(64'd1234567);
    load_settings(5'd3, {$urandom, $urandom}, {$urandom, $urandom});
    send_value(ALL_ONES);

    for (int ph = 0; ph < PHASES; ph++) begin
      case ($urandom_range(0, 9))
        0:       b = BASE_W'($urandom_range(0, 1));
        1:       b = BASE_W'($urandom_range(17, 31));
        default: b = BASE_W'($urandom_range(2, 16));
      endcase
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      if ($urandom_range(0, 4) == 0) begin
        lo = RESET_ALPHA_LOW;
        hi = RESET_ALPHA_HIGH;
      end
      load_settings(b, lo, hi);
      calm = (ph == PHASES - 1);
      case ($urandom_range(0, 3))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        2:       gap_pct = 30;
        default: gap_pct = 60;
      endcase
      radix = VALUE_W'(cur_base);
      if (radix < 2) radix = 2;
      if (radix > MAX_BASE) radix = MAX_BASE;
      repeat (30 + $urandom_range(0, 4)) begin
        case ($urandom_range(0, 9))
          0: v = VALUE_W'($urandom_range(0, 40));
          1: v = ($urandom_range(0, 1) != 0) ? ALL_ONES : '0;
          2, 3: begin
            // around a power of the base, where the digit count changes
            p = 1;
            n = $urandom_range(1, 63);
            repeat (n) begin
              if (p <= ALL_ONES / radix) p = p * radix;
            end
            v = p - VALUE_W'($urandom_range(0, 1));
          end
          4, 5, 6: v = {$urandom, $urandom} >> $urandom_range(0, 63);
          default: v = {$urandom, $urandom};
        endcase
        send_value(v);
      end
    end

    drain(DRAIN_CYCLES);
    if (errors == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/utrd_pkg.sv
hdl/utrd_fifo.sv
hdl/utrd_front.sv
hdl/utrd_back.sv
hdl/unsigned_to_radix_digits.sv
sim/radix_digit_checker.sv
sim/unsigned_to_radix_digits_tb.sv
